/* rtl/arwf_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the
// auto-ranging window filter. No dependencies.
package arwf_pkg;

   localparam int CHANNELS      = 8;
   localparam int SAMPLE_BITS   = 10;
   localparam int SCALE_BITS    = 4;

   localparam int CHANNEL_BITS  = 3;
   localparam int VALUE_BITS    = 10;
   localparam int OUT_SCALE_BITS = 4;
   localparam int THRESH_BITS   = 10;
   localparam int TERM_BITS     = 8;
   localparam int COUNT_BITS    = 8;
   localparam int ACC_BITS      = SAMPLE_BITS + TERM_BITS;
   localparam int STEP_BITS     = $clog2(ACC_BITS);
   localparam int CHAN_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      MODE_RAW = 2'd0,
      MODE_MIN = 2'd1,
      MODE_MAX = 2'd2,
      MODE_AVG = 2'd3
   } filter_mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FILTER_MODE    = 3'd0,
      REG_WINDOW_TERMS   = 3'd1,
      REG_AUTORANGE_MASK = 3'd2,
      REG_HIGH_THRESHOLD = 3'd3,
      REG_LOW_THRESHOLD  = 3'd4,
      REG_RETRY_LIMIT    = 3'd5,
      REG_MAX_SCALE      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic load;       // take the accepted request into the window
      logic div_start;  // load the divider with the accumulator
      logic div_step;   // one quotient bit
      logic commit;     // settle the window, step the scale, fill the result register
   } dp_cmd_type;

   typedef struct packed {
      logic window_done;
      logic avg_mode;
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/arwf_req_if.sv */
// Request channel of the window filter: valid/ready with one sample.
// Depends on arwf_pkg.
interface arwf_req_if;
   logic                                valid;
   logic                                ready;
   logic [arwf_pkg::CHANNEL_BITS-1:0]   channel;
   logic [arwf_pkg::SAMPLE_BITS-1:0]    sample;
   logic                                start_req;

   modport source (output valid, output channel, output sample, output start_req,
                   input ready);
   modport sink   (input valid, input channel, input sample, input start_req,
                   output ready);
endinterface

/* rtl/arwf_rsp_if.sv */
// Response channel of the window filter: valid/ready with one window result.
// Depends on arwf_pkg.
interface arwf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [arwf_pkg::VALUE_BITS-1:0]      value;
   logic [arwf_pkg::CHANNEL_BITS-1:0]    out_channel;
   logic [arwf_pkg::OUT_SCALE_BITS-1:0]  scale;
   logic                                 scale_changed;
   logic                                 final_res;

   modport source (output valid, output value, output out_channel, output scale,
                   output scale_changed, output final_res, input ready);
   modport sink   (input valid, input value, input out_channel, input scale,
                   input scale_changed, input final_res, output ready);
endinterface

/* rtl/arwf_ctrl.sv */
// Sequencer of the window filter: accepts a request, checks for window end,
// runs the divider for averages and commits the result. Depends on arwf_pkg.
module arwf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  arwf_pkg::dp_status_type status,
   output arwf_pkg::dp_cmd_type    cmd
);
   import arwf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   state_type              state_ff;
   logic                   ready_ff;
   logic [STEP_BITS-1:0]   step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid && ready_ff) begin
                  state_ff <= ST_EVAL;
                  ready_ff <= 1'b0;
               end
            end
            ST_EVAL: begin
               if (!status.window_done) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end else if (status.avg_mode) begin
                  state_ff <= ST_DIVIDE;
                  step_ff  <= '0;
               end else begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_BITS'(ACC_BITS - 1)) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign in_ready = ready_ff;

   always_comb begin
      cmd.load      = (state_ff == ST_IDLE) && in_valid && ready_ff;
      cmd.div_start = (state_ff == ST_EVAL) && status.window_done && status.avg_mode;
      cmd.div_step  = (state_ff == ST_DIVIDE);
      cmd.commit    = (state_ff == ST_COMMIT) && status.out_free;
   end

endmodule

/* rtl/arwf_datapath.sv */
// Datapath of the window filter: configuration registers, window state,
// bit-serial divider, scale stepping and result register. Depends on arwf_pkg.
module arwf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [arwf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [arwf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  arwf_pkg::dp_cmd_type                 cmd,
   output arwf_pkg::dp_status_type              status,
   input  logic [arwf_pkg::CHANNEL_BITS-1:0]    in_channel,
   input  logic [arwf_pkg::SAMPLE_BITS-1:0]     in_sample,
   input  logic                                 in_start,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic [arwf_pkg::VALUE_BITS-1:0]      out_value,
   output logic [arwf_pkg::CHANNEL_BITS-1:0]    out_channel,
   output logic [arwf_pkg::OUT_SCALE_BITS-1:0]  out_scale,
   output logic                                 out_changed,
   output logic                                 out_final
);
   import arwf_pkg::*;

   localparam logic [SCALE_BITS-1:0] SCALE_TOP = {SCALE_BITS{1'b1}};

   // Configuration registers.
   filter_mode_type          filter_mode_ff;
   logic [TERM_BITS-1:0]     window_terms_ff;
   logic [7:0]               autorange_mask_ff;
   logic [THRESH_BITS-1:0]   high_threshold_ff;
   logic [THRESH_BITS-1:0]   low_threshold_ff;
   logic [COUNT_BITS-1:0]    retry_limit_ff;
   logic [31:0]              max_scale_ff;

   // Window and read state.
   logic [COUNT_BITS-1:0]    wcount_ff;
   logic [ACC_BITS-1:0]      acc_ff;
   logic [SAMPLE_BITS-1:0]   ext_ff;
   logic [COUNT_BITS-1:0]    retry_ff;
   logic [SCALE_BITS-1:0]    scale_ff [CHANNELS];
   logic [CHANNEL_BITS-1:0]  ch_ff;
   logic [SAMPLE_BITS-1:0]   smp_ff;

   // Divider.
   logic [ACC_BITS-1:0]      quot_ff;
   logic [TERM_BITS-1:0]     rem_ff;

   // Result register.
   logic                     out_valid_ff;
   logic [VALUE_BITS-1:0]    out_value_ff;
   logic [CHANNEL_BITS-1:0]  out_channel_ff;
   logic [OUT_SCALE_BITS-1:0] out_scale_ff;
   logic                     out_changed_ff;
   logic                     out_final_ff;

   // Accumulate path.
   logic [COUNT_BITS-1:0]    wc_base;
   logic [ACC_BITS-1:0]      acc_base;
   logic [SAMPLE_BITS-1:0]   ext_base;
   logic [SAMPLE_BITS-1:0]   ext_in;
   logic [COUNT_BITS-1:0]    wcount_in;
   logic [ACC_BITS-1:0]      acc_in;
   logic [TERM_BITS-1:0]     terms_eff;

   // Divide path.
   logic [TERM_BITS:0]       trial;
   logic                     trial_ge;
   logic [TERM_BITS:0]       trial_diff;
   logic [TERM_BITS-1:0]     rem_in;
   logic [ACC_BITS-1:0]      quot_in;

   // Commit path.
   logic [ACC_BITS-1:0]      result;
   logic                     in_range;
   logic [CHAN_IDX_BITS-1:0] ch_idx;
   logic [SCALE_BITS-1:0]    cur_scale;
   logic [3:0]               maxs_raw;
   logic [7:0]               maxs_wide;
   logic [7:0]               maxs_clamped;
   logic [SCALE_BITS-1:0]    maxs;
   logic                     ar_en;
   logic                     hit_high;
   logic                     hit_low;
   logic                     step_up;
   logic                     step_down;
   logic [SCALE_BITS-1:0]    scale_in;
   logic                     changed;
   logic [COUNT_BITS-1:0]    retry_next;
   logic [COUNT_BITS-1:0]    limit;
   logic                     is_final;

   always_comb begin
      wc_base  = in_start ? '0 : wcount_ff;
      acc_base = in_start ? '0 : acc_ff;
      ext_base = in_start ? '0 : ext_ff;

      // The first sample of a window seeds the extreme.
      if (wc_base == '0) begin
         ext_in = in_sample;
      end else if (filter_mode_ff == MODE_MIN && in_sample < ext_base) begin
         ext_in = in_sample;
      end else if (filter_mode_ff == MODE_MAX && in_sample > ext_base) begin
         ext_in = in_sample;
      end else begin
         ext_in = ext_base;
      end
      acc_in    = acc_base + ACC_BITS'(in_sample);
      wcount_in = (wc_base != {COUNT_BITS{1'b1}}) ? wc_base + 1'b1 : wc_base;

      if (filter_mode_ff == MODE_RAW || window_terms_ff == '0) begin
         terms_eff = TERM_BITS'(1);
      end else begin
         terms_eff = window_terms_ff;
      end
   end

   always_comb begin
      status.window_done = (wcount_ff >= terms_eff);
      status.avg_mode    = (filter_mode_ff == MODE_AVG);
      status.out_free    = !out_valid_ff || out_ready;
   end

   // Restoring division, one quotient bit a cycle, dividend shifted out of quot_ff.
   always_comb begin
      trial      = {rem_ff, quot_ff[ACC_BITS-1]};
      trial_ge   = (trial >= {1'b0, terms_eff});
      trial_diff = trial - {1'b0, terms_eff};
      rem_in     = trial_ge ? trial_diff[TERM_BITS-1:0] : trial[TERM_BITS-1:0];
      quot_in    = {quot_ff[ACC_BITS-2:0], trial_ge};
   end

   always_comb begin
      case (filter_mode_ff)
         MODE_RAW: result = ACC_BITS'(smp_ff);
         MODE_AVG: result = quot_ff;
         default:  result = ACC_BITS'(ext_ff);
      endcase

      in_range  = ({1'b0, ch_ff} < (CHANNEL_BITS + 1)'(CHANNELS));
      ch_idx    = ch_ff[CHAN_IDX_BITS-1:0];
      cur_scale = in_range ? scale_ff[ch_idx] : '0;

      maxs_raw     = max_scale_ff[{ch_ff, 2'b00} +: 4];
      maxs_wide    = {4'b0000, maxs_raw};
      maxs_clamped = (maxs_wide > 8'(SCALE_TOP)) ? 8'(SCALE_TOP) : maxs_wide;
      maxs         = maxs_clamped[SCALE_BITS-1:0];

      ar_en    = in_range && autorange_mask_ff[ch_ff];
      hit_high = (result >= ACC_BITS'(high_threshold_ff));
      hit_low  = (result <= ACC_BITS'(low_threshold_ff));

      // A channel with no maximum scale is fixed and never steps.
      step_up   = ar_en && (maxs != '0) && hit_high && (cur_scale < maxs);
      step_down = ar_en && (maxs != '0) && !hit_high && hit_low && (cur_scale != '0);
      changed   = step_up || step_down;

      if (step_up) begin
         scale_in = cur_scale + 1'b1;
      end else if (step_down) begin
         scale_in = cur_scale - 1'b1;
      end else begin
         scale_in = cur_scale;
      end

      if (ar_en && retry_ff != {COUNT_BITS{1'b1}}) begin
         retry_next = retry_ff + 1'b1;
      end else begin
         retry_next = retry_ff;
      end
      limit    = (retry_limit_ff == '0) ? COUNT_BITS'(1) : retry_limit_ff;
      is_final = !(changed && (retry_next < limit));
   end

   // Configuration, window, read and scale state.
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff    <= MODE_RAW;
         window_terms_ff   <= TERM_BITS'(1);
         autorange_mask_ff <= '0;
         high_threshold_ff <= {THRESH_BITS{1'b1}};
         low_threshold_ff  <= '0;
         retry_limit_ff    <= COUNT_BITS'(4);
         max_scale_ff      <= '0;
         wcount_ff         <= '0;
         acc_ff            <= '0;
         ext_ff            <= '0;
         retry_ff          <= '0;
         out_valid_ff      <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            scale_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_FILTER_MODE:    filter_mode_ff    <= filter_mode_type'(csr_wdata[1:0]);
               REG_WINDOW_TERMS:   window_terms_ff   <= csr_wdata[TERM_BITS-1:0];
               REG_AUTORANGE_MASK: autorange_mask_ff <= csr_wdata[7:0];
               REG_HIGH_THRESHOLD: high_threshold_ff <= csr_wdata[THRESH_BITS-1:0];
               REG_LOW_THRESHOLD:  low_threshold_ff  <= csr_wdata[THRESH_BITS-1:0];
               REG_RETRY_LIMIT:    retry_limit_ff    <= csr_wdata[COUNT_BITS-1:0];
               REG_MAX_SCALE:      max_scale_ff      <= csr_wdata[31:0];
               default: ;
            endcase
         end

         if (cmd.load) begin
            wcount_ff <= wcount_in;
            acc_ff    <= acc_in;
            ext_ff    <= ext_in;
            if (in_start) begin
               retry_ff <= '0;
            end
         end else if (cmd.commit) begin
            wcount_ff <= '0;
            acc_ff    <= '0;
            ext_ff    <= '0;
            retry_ff  <= is_final ? '0 : retry_next;
            if (ar_en) begin
               scale_ff[ch_idx] <= scale_in;
            end
         end

         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff  <= in_channel;
         smp_ff <= in_sample;
      end
      if (cmd.div_start) begin
         quot_ff <= acc_ff;
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
      if (cmd.commit) begin
         out_value_ff   <= result[VALUE_BITS-1:0];
         out_channel_ff <= ch_ff;
         out_scale_ff   <= OUT_SCALE_BITS'(scale_in);
         out_changed_ff <= changed;
         out_final_ff   <= is_final;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_value   = out_value_ff;
   assign out_channel = out_channel_ff;
   assign out_scale   = out_scale_ff;
   assign out_changed = out_changed_ff;
   assign out_final   = out_final_ff;

endmodule

/* rtl/adc_autorange_window_filter_unit.sv */
// Top level of the auto-ranging window filter: sequencer plus datapath.
// Depends on arwf_pkg, arwf_req_if, arwf_rsp_if, arwf_ctrl and arwf_datapath.
//
//   port      direction  carries
//   req_ch    in         one sample request: channel, sample, start_req
//   rsp_ch    out        one window result: value, out_channel, scale, flags
//   csr_*     in         register writes: csr_we, csr_index, csr_wdata
//
// A request that does not close a window passes through ST_IDLE and ST_EVAL;
// one that closes a raw, minimum or maximum window goes on to ST_COMMIT, and
// one that closes an average window runs ST_DIVIDE before ST_COMMIT, the
// bit-serial divider producing one quotient bit per cycle of the 18-bit
// accumulator. Reset is synchronous and active high and sets the configuration
// registers to their defaults and the window, result valid and channel scales to zero.
// The result register frees the request side: a new request is taken while a
// result waits, and only the commit of the next result waits for rsp_ch.ready.
module adc_autorange_window_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   arwf_req_if.sink                             req_ch,
   arwf_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [arwf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [arwf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import arwf_pkg::*;

   // Commands flow from the sequencer to the datapath, status flows back.
   dp_cmd_type    cmd;
   dp_status_type status;

   arwf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath owns the configuration registers, the window, the divider
   // and the result register that drives the response channel.
   arwf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .in_channel  (req_ch.channel),
      .in_sample   (req_ch.sample),
      .in_start    (req_ch.start_req),
      .out_ready   (rsp_ch.ready),
      .out_valid   (rsp_ch.valid),
      .out_value   (rsp_ch.value),
      .out_channel (rsp_ch.out_channel),
      .out_scale   (rsp_ch.scale),
      .out_changed (rsp_ch.scale_changed),
      .out_final   (rsp_ch.final_res)
   );

endmodule
